FILE: hw/rtl/vrp_pkg.sv
// Shared types and constants for the vector rotate and polar pipeline.
// No dependencies; used by vrp_cordic_stage and vector_rotate_and_polar.
package vrp_pkg;

  // Angle datapath width: 16 extra fraction bits below the binary angle, one turn is 2^32,
  // plus sign headroom.
  localparam int unsigned ZW = 33;
  localparam int unsigned ANG_FRAC = 16;

  // Reciprocal CORDIC gain, Q0.20 (about 1/1.64676).
  localparam int unsigned KINV_FRAC = 20;
  localparam logic signed [21:0] KINV = 22'sd636750;

  // Quarter turn in input angle units, and half a turn in datapath units.
  localparam logic signed [15:0] QUARTER_IN = 16'sd16384;
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);

  // Direction result limits and rounding constant.
  localparam logic signed [ZW-1:0] DIR_HI = ZW'(64'sd16384);
  localparam logic signed [ZW-1:0] DIR_LO = ZW'(-64'sd16384);
  localparam logic signed [ZW-1:0] DIR_HALF = ZW'(64'sd32768);

  // atan(2^-i) in datapath angle units.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [1:0] {
    MODE_ROTATE  = 2'd0,
    MODE_MEASURE = 2'd1,
    MODE_SETDIR  = 2'd2
  } mode_e;

  // Sideband that travels with every item down the pipeline.
  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic signed [15:0] angle;
    logic               vec_act;
  } side_t;

endpackage

FILE: hw/rtl/vrp_cordic_stage.sv
// One registered CORDIC micro-rotation, vectoring or rotation flavour.
// Depends on vrp_pkg for the arctangent table, the mode codes and the sideband type.
module vrp_cordic_stage #(
  parameter int unsigned W         = 28,
  parameter int unsigned SHIFT     = 0,
  parameter bit          VECTORING = 1'b1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  vrp_pkg::side_t             side_i,
  input  logic signed [W-1:0]        x_i,
  input  logic signed [W-1:0]        y_i,
  input  logic signed [vrp_pkg::ZW-1:0] z_i,
  output logic                       valid_o,
  output vrp_pkg::side_t             side_o,
  output logic signed [W-1:0]        x_o,
  output logic signed [W-1:0]        y_o,
  output logic signed [vrp_pkg::ZW-1:0] z_o
);

  localparam logic signed [vrp_pkg::ZW-1:0] ATAN = vrp_pkg::ZW'(vrp_pkg::ATAN_TAB[SHIFT]);

  logic                          active;
  logic                          pos;
  logic signed [W-1:0]           dx, dy;
  logic signed [W-1:0]           x_d, y_d;
  logic signed [vrp_pkg::ZW-1:0] z_d;
  logic                          valid_q;
  vrp_pkg::side_t                side_q;
  logic signed [W-1:0]           x_q, y_q;
  logic signed [vrp_pkg::ZW-1:0] z_q;

  always_comb begin
    if (VECTORING) begin
      active = side_i.vec_act;
      pos    = y_i[W-1];
    end else begin
      active = (side_i.mode == vrp_pkg::MODE_ROTATE) || (side_i.mode == vrp_pkg::MODE_SETDIR);
      pos    = !z_i[vrp_pkg::ZW-1];
    end
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (!active) begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (pos) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

FILE: hw/rtl/vector_rotate_and_polar.sv
// Top level of the vector rotate and polar pipeline (CORDIC rotation and vectoring).
// Depends on vrp_pkg and vrp_cordic_stage.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------------
//  in      | in        | in_valid_i / in_stall_o  | mode_i, x_in_i, y_in_i, angle_in_i
//  out     | out       | out_valid_o / out_stall_i| x_out_o, y_out_o, magnitude_o, direction_o,
//          |           |                          | clipped_o
//
// One item enters per cycle while in_stall_o is low; its result passes through the input
// register, the ITERATIONS vectoring stages, two gain stages, the ITERATIONS rotation stages
// and two output stages.
// Reset clears only the valid bits; the pipeline is empty straight after reset.
// A result held in the output register while out_stall_i is high freezes every stage and
// raises in_stall_o, so no item is lost or repeated.
module vector_rotate_and_polar #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] x_in_i,
  input  logic signed [15:0] y_in_i,
  input  logic signed [15:0] angle_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] x_out_o,
  output logic signed [15:0] y_out_o,
  output logic [15:0]        magnitude_o,
  output logic signed [15:0] direction_o,
  output logic               clipped_o
);

  // Guard fraction bits below the Q8.8 LSB, datapath width with growth headroom,
  // and the width of a product with the reciprocal gain.
  localparam int unsigned G  = DATA_WIDTH - 8;
  localparam int unsigned W  = DATA_WIDTH + 12;
  localparam int unsigned PW = W + 22;
  localparam int unsigned ZW = vrp_pkg::ZW;

  localparam logic signed [PW-1:0] HALF_R  = PW'(1) <<< (vrp_pkg::KINV_FRAC - 1);
  localparam logic signed [PW-1:0] HALF_G  = PW'(1) <<< (vrp_pkg::KINV_FRAC + G - 1);
  localparam logic signed [PW-1:0] SAT_HI  = PW'(32767);
  localparam logic signed [PW-1:0] SAT_LO  = PW'(-32768);
  localparam logic signed [PW-1:0] MAG_HI  = PW'(65535);
  localparam logic signed [PW-1:0] KINV_PW = PW'(vrp_pkg::KINV);

  // Whole pipeline advances together unless the output register holds an untaken result.
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- input register
  logic                 vec_valid [ITERATIONS+1];
  vrp_pkg::side_t       vec_side  [ITERATIONS+1];
  logic signed [W-1:0]  vec_x     [ITERATIONS+1];
  logic signed [W-1:0]  vec_y     [ITERATIONS+1];
  logic signed [ZW-1:0] vec_z     [ITERATIONS+1];

  vrp_pkg::mode_e      in_mode;
  logic signed [W-1:0] xe, ye, xa, ya, in_x_d, in_y_d;
  logic                in_vec_act;
  vrp_pkg::side_t      in_side_d;

  always_comb begin
    in_mode    = vrp_pkg::mode_e'(mode_i);
    xe         = W'(x_in_i) <<< G;
    ye         = W'(y_in_i) <<< G;
    // Fold the left half-plane onto the right: atan(y/x) does not change.
    xa         = xe[W-1] ? -xe : xe;
    ya         = xe[W-1] ? -ye : ye;
    in_vec_act = 1'b0;
    unique case (mode_i)
      vrp_pkg::MODE_ROTATE: begin
        in_x_d = xe;
        in_y_d = ye;
      end
      vrp_pkg::MODE_MEASURE, vrp_pkg::MODE_SETDIR: begin
        if (x_in_i != 16'sd0) begin
          in_vec_act = 1'b1;
          in_x_d     = xa;
          in_y_d     = ya;
        end else begin
          // On the y axis the length is |y| and needs no gain removal.
          in_x_d = ye[W-1] ? -ye : ye;
          in_y_d = '0;
        end
      end
      default: begin
        in_x_d = '0;
        in_y_d = '0;
      end
    endcase
    in_side_d.mode    = in_mode;
    in_side_d.x_in    = x_in_i;
    in_side_d.y_in    = y_in_i;
    in_side_d.angle   = angle_in_i;
    in_side_d.vec_act = in_vec_act;
  end

  logic in_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  vrp_pkg::side_t      in_side_q;
  logic signed [W-1:0] in_x_q, in_y_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_side_q <= in_side_d;
      in_x_q    <= in_x_d;
      in_y_q    <= in_y_d;
    end
  end

  assign vec_valid[0] = in_valid_q;
  assign vec_side[0]  = in_side_q;
  assign vec_x[0]     = in_x_q;
  assign vec_y[0]     = in_y_q;
  assign vec_z[0]     = '0;

  // ---------------------------------------------------------------- vectoring stages
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_vec
    vrp_cordic_stage #(
      .W         (W),
      .SHIFT     (i),
      .VECTORING (1'b1)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vec_valid[i]),
      .side_i  (vec_side[i]),
      .x_i     (vec_x[i]),
      .y_i     (vec_y[i]),
      .z_i     (vec_z[i]),
      .valid_o (vec_valid[i+1]),
      .side_o  (vec_side[i+1]),
      .x_o     (vec_x[i+1]),
      .y_o     (vec_y[i+1]),
      .z_o     (vec_z[i+1])
    );
  end

  // ---------------------------------------------------------------- gain removal on length
  logic                 m1_valid_q;
  vrp_pkg::side_t       m1_side_q;
  logic signed [W-1:0]  m1_x_q, m1_y_q;
  logic signed [ZW-1:0] m1_z_q;
  logic signed [PW-1:0] m1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= vec_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_side_q <= vec_side[ITERATIONS];
      m1_x_q    <= vec_x[ITERATIONS];
      m1_y_q    <= vec_y[ITERATIONS];
      m1_z_q    <= vec_z[ITERATIONS];
      m1_prod_q <= PW'(vec_x[ITERATIONS]) * KINV_PW;
    end
  end

  // Round the compensated length, pick the rotation operands and fold the angle into
  // [-quarter, quarter] turn by negating the vector.
  logic signed [PW-1:0] r_full;
  logic signed [W-1:0]  r_len, rx, ry, rx_d, ry_d;
  logic signed [ZW-1:0] z0, rz_d;
  logic                 rot_mode, far_pos, far_neg;

  always_comb begin
    r_full   = (m1_prod_q + HALF_R) >>> vrp_pkg::KINV_FRAC;
    r_len    = m1_side_q.vec_act ? r_full[W-1:0] : m1_x_q;
    z0       = ZW'(m1_side_q.angle) <<< vrp_pkg::ANG_FRAC;
    rot_mode = (m1_side_q.mode == vrp_pkg::MODE_ROTATE) ||
               (m1_side_q.mode == vrp_pkg::MODE_SETDIR);
    far_pos  = rot_mode && (m1_side_q.angle > vrp_pkg::QUARTER_IN);
    far_neg  = rot_mode && (m1_side_q.angle < -vrp_pkg::QUARTER_IN);
    unique case (m1_side_q.mode)
      vrp_pkg::MODE_ROTATE: begin
        rx   = m1_x_q;
        ry   = m1_y_q;
        rz_d = z0;
      end
      vrp_pkg::MODE_SETDIR: begin
        rx   = r_len;
        ry   = '0;
        rz_d = z0;
      end
      default: begin
        // Measure: carry the vectoring length and angle through untouched.
        rx   = m1_x_q;
        ry   = m1_y_q;
        rz_d = m1_z_q;
      end
    endcase
    rx_d = rx;
    ry_d = ry;
    priority if (far_pos) begin
      rx_d = -rx;
      ry_d = -ry;
      rz_d = z0 - vrp_pkg::HALF_TURN;
    end else if (far_neg) begin
      rx_d = -rx;
      ry_d = -ry;
      rz_d = z0 + vrp_pkg::HALF_TURN;
    end else begin
      rx_d = rx;
    end
  end

  logic                 m2_valid_q;
  vrp_pkg::side_t       m2_side_q;
  logic signed [W-1:0]  m2_x_q, m2_y_q;
  logic signed [ZW-1:0] m2_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_side_q <= m1_side_q;
      m2_x_q    <= rx_d;
      m2_y_q    <= ry_d;
      m2_z_q    <= rz_d;
    end
  end

  // ---------------------------------------------------------------- rotation stages
  logic                 rot_valid [ITERATIONS+1];
  vrp_pkg::side_t       rot_side  [ITERATIONS+1];
  logic signed [W-1:0]  rot_x     [ITERATIONS+1];
  logic signed [W-1:0]  rot_y     [ITERATIONS+1];
  logic signed [ZW-1:0] rot_z     [ITERATIONS+1];

  assign rot_valid[0] = m2_valid_q;
  assign rot_side[0]  = m2_side_q;
  assign rot_x[0]     = m2_x_q;
  assign rot_y[0]     = m2_y_q;
  assign rot_z[0]     = m2_z_q;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    vrp_cordic_stage #(
      .W         (W),
      .SHIFT     (i),
      .VECTORING (1'b0)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rot_valid[i]),
      .side_i  (rot_side[i]),
      .x_i     (rot_x[i]),
      .y_i     (rot_y[i]),
      .z_i     (rot_z[i]),
      .valid_o (rot_valid[i+1]),
      .side_o  (rot_side[i+1]),
      .x_o     (rot_x[i+1]),
      .y_o     (rot_y[i+1]),
      .z_o     (rot_z[i+1])
    );
  end

  // ---------------------------------------------------------------- gain removal on outputs
  logic                 f1_valid_q;
  vrp_pkg::side_t       f1_side_q;
  logic signed [ZW-1:0] f1_z_q;
  logic signed [PW-1:0] f1_px_q, f1_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= rot_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_side_q <= rot_side[ITERATIONS];
      f1_z_q    <= rot_z[ITERATIONS];
      f1_px_q   <= PW'(rot_x[ITERATIONS]) * KINV_PW;
      f1_py_q   <= PW'(rot_y[ITERATIONS]) * KINV_PW;
    end
  end

  // Round half up to Q8.8, saturate components, clamp length and direction.
  logic signed [PW-1:0] xr, yr;
  logic signed [ZW-1:0] dz;
  logic signed [15:0]   xs, ys, x_out_d, y_out_d, dir_d;
  logic [15:0]          mag_d;
  logic                 x_clip, y_clip, clip_d;

  always_comb begin
    xr     = (f1_px_q + HALF_G) >>> (vrp_pkg::KINV_FRAC + G);
    yr     = (f1_py_q + HALF_G) >>> (vrp_pkg::KINV_FRAC + G);
    x_clip = (xr > SAT_HI) || (xr < SAT_LO);
    y_clip = (yr > SAT_HI) || (yr < SAT_LO);
    xs     = (xr > SAT_HI) ? 16'sh7fff : ((xr < SAT_LO) ? -16'sh8000 : xr[15:0]);
    ys     = (yr > SAT_HI) ? 16'sh7fff : ((yr < SAT_LO) ? -16'sh8000 : yr[15:0]);
    dz     = (f1_z_q + vrp_pkg::DIR_HALF) >>> vrp_pkg::ANG_FRAC;
    unique case (f1_side_q.mode)
      vrp_pkg::MODE_ROTATE, vrp_pkg::MODE_SETDIR: begin
        x_out_d = xs;
        y_out_d = ys;
        mag_d   = '0;
        dir_d   = '0;
        clip_d  = x_clip || y_clip;
      end
      vrp_pkg::MODE_MEASURE: begin
        x_out_d = f1_side_q.x_in;
        y_out_d = f1_side_q.y_in;
        clip_d  = 1'b0;
        if (!f1_side_q.vec_act) begin
          // On the y axis: length |y|, direction plus or minus a quarter turn, or 0.
          mag_d = f1_side_q.y_in[15] ? 16'(-f1_side_q.y_in) : 16'(f1_side_q.y_in);
          if (f1_side_q.y_in == 16'sd0) begin
            dir_d = '0;
          end else begin
            dir_d = f1_side_q.y_in[15] ? -vrp_pkg::QUARTER_IN : vrp_pkg::QUARTER_IN;
          end
        end else begin
          mag_d = xr[PW-1] ? 16'd0 : ((xr > MAG_HI) ? 16'hffff : xr[15:0]);
          dir_d = (dz > vrp_pkg::DIR_HI) ? vrp_pkg::QUARTER_IN :
                  ((dz < vrp_pkg::DIR_LO) ? -vrp_pkg::QUARTER_IN : dz[15:0]);
        end
      end
      default: begin
        x_out_d = '0;
        y_out_d = '0;
        mag_d   = '0;
        dir_d   = '0;
        clip_d  = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- output register
  logic               out_valid_q;
  vrp_pkg::mode_e     out_mode_q;
  logic signed [15:0] x_out_q, y_out_q, dir_q;
  logic [15:0]        mag_q;
  logic               clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_mode_q <= f1_side_q.mode;
      x_out_q    <= x_out_d;
      y_out_q    <= y_out_d;
      mag_q      <= mag_d;
      dir_q      <= dir_d;
      clip_q     <= clip_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;
  assign magnitude_o = mag_q;
  assign direction_o = dir_q;
  assign clipped_o   = clip_q;

  // ---------------------------------------------------------------- assertions
  // Input side only stalls because an untaken result blocks the output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A measurement never saturates its component outputs.
  a_measure_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !(out_mode_q == vrp_pkg::MODE_ROTATE ||
                      out_mode_q == vrp_pkg::MODE_SETDIR)) |-> !clipped_o)
    else $error("clip flag raised on a non-rotating result");

  // Only a measurement carries length and direction.
  a_polar_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_mode_q != vrp_pkg::MODE_MEASURE) |->
      (magnitude_o == 16'd0 && direction_o == 16'sd0))
    else $error("length or direction set outside measure mode");

  // Direction stays within the right half-plane.
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (direction_o <= vrp_pkg::QUARTER_IN && direction_o >= -vrp_pkg::QUARTER_IN))
    else $error("direction outside plus or minus a quarter turn");

endmodule
